// ===== src/etc_pkg.sv =====
package etc_pkg;

   // Table geometry and counter widths
   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int PKT_W         = 32;
   localparam int BYTE_W        = 48;
   localparam int LEN_W         = 16;
   localparam int ADDR_W        = 32;
   localparam int PORT_W        = 16;
   localparam int KEY_W         = 1 + ADDR_W + PORT_W;

   // Fixed widths of the result fields
   localparam int SLOT_OUT_W = 8;
   localparam int PKT_OUT_W  = 32;
   localparam int BYTE_OUT_W = 48;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [1:0] KIND_TCP   = 2'd0;
   localparam logic [1:0] KIND_UDP   = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   localparam logic [1:0] ST_UPDATED  = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTCNT   = 2'd3;

   // One classified packet, as queued between front and back
   typedef struct packed {
      logic              other;
      logic              udp;
      logic [ADDR_W-1:0] src_address;
      logic [PORT_W-1:0] source_port;
      logic [ADDR_W-1:0] dst_address;
      logic [PORT_W-1:0] dest_port;
      logic [LEN_W-1:0]  frame_length;
   } job_type;

   // Counters of one table entry
   typedef struct packed {
      logic [PKT_W-1:0]  tx_p;
      logic [BYTE_W-1:0] tx_b;
      logic [PKT_W-1:0]  rx_p;
      logic [BYTE_W-1:0] rx_b;
   } stats_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

endpackage

// ===== src/etc_if.sv =====
interface etc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  ip_protocol;
   logic [31:0] src_address;
   logic [15:0] source_port;
   logic [31:0] dst_address;
   logic [15:0] dest_port;
   logic [15:0] frame_length;

   modport source (output valid, ip_protocol, src_address, source_port, dst_address,
                   dest_port, frame_length, input ready);
   modport sink (input valid, ip_protocol, src_address, source_port, dst_address,
                 dest_port, frame_length, output ready);
endinterface

interface etc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  proto_kind;
   logic [31:0] entry_address;
   logic [15:0] entry_port;
   logic        direction;
   logic [7:0]  slot;
   logic [1:0]  status;
   logic [31:0] tx_packet_count;
   logic [47:0] tx_byte_count;
   logic [31:0] rx_packet_count;
   logic [47:0] rx_byte_count;
   logic        last_of_packet;

   modport source (output valid, proto_kind, entry_address, entry_port, direction,
                   slot, status, tx_packet_count, tx_byte_count, rx_packet_count,
                   rx_byte_count, last_of_packet, input ready);
   modport sink (input valid, proto_kind, entry_address, entry_port, direction,
                 slot, status, tx_packet_count, tx_byte_count, rx_packet_count,
                 rx_byte_count, last_of_packet, output ready);
endinterface

// ===== src/etc_front.sv =====
module etc_front (
   input  logic                    clock,
   input  logic                    reset,
   etc_req_if.sink                 req_ch,
   output etc_pkg::queue_head_type head,
   input  logic                    pop
);

   etc_pkg::job_type job;
   etc_pkg::job_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;

   // Classify the packet by protocol
   always_comb begin
      job.other        = (req_ch.ip_protocol != etc_pkg::PROTO_TCP) &&
                         (req_ch.ip_protocol != etc_pkg::PROTO_UDP);
      job.udp          = (req_ch.ip_protocol == etc_pkg::PROTO_UDP);
      job.src_address  = req_ch.src_address;
      job.source_port  = req_ch.source_port;
      job.dst_address  = req_ch.dst_address;
      job.dest_port    = req_ch.dest_port;
      job.frame_length = req_ch.frame_length;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign head.valid   = (count_ff != 2'd0);
   assign head.job     = q_ff[rd_ptr_ff];

   // Two-entry queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job;
      end
   end

endmodule

// ===== src/etc_back.sv =====
module etc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  etc_pkg::queue_head_type head,
   output logic                    pop,
   etc_rsp_if.source               rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_READ  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [1:0]                   proto_kind;
      logic [etc_pkg::ADDR_W-1:0]   entry_address;
      logic [etc_pkg::PORT_W-1:0]   entry_port;
      logic                         direction;
      logic [etc_pkg::IDX_W-1:0]    slot;
      logic [1:0]                   status;
      etc_pkg::stats_type           stats;
      logic                         last_of_packet;
   } result_type;

   state_type                   state_ff, state_in;
   etc_pkg::job_type            job_ff, job_in;
   logic                        side_ff, side_in;
   logic [etc_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [etc_pkg::IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [etc_pkg::IDX_W-1:0]   slot_ff, slot_in;
   logic [1:0]                  status_ff, status_in;
   logic [etc_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic                        out_vld_ff, out_vld_in;
   result_type                  out_ff, out_in;
   logic                        out_load;

   logic [etc_pkg::KEY_W-1:0]   key_mem [etc_pkg::TABLE_ENTRIES];
   etc_pkg::stats_type          stats_mem [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::KEY_W-1:0]   key_rd_ff;
   etc_pkg::stats_type          stats_rd_ff;
   logic                        key_we, stats_we;

   logic [etc_pkg::KEY_W-1:0]   cur_key;
   logic [etc_pkg::ADDR_W-1:0]  cur_addr;
   logic [etc_pkg::PORT_W-1:0]  cur_port;
   etc_pkg::stats_type          base, upd;
   logic [etc_pkg::PKT_W:0]     pkt_sum;
   logic [etc_pkg::BYTE_W:0]    byte_sum;
   logic [etc_pkg::PKT_W-1:0]   pkt_cur;
   logic [etc_pkg::BYTE_W-1:0]  byte_cur;
   logic [etc_pkg::PKT_W-1:0]   pkt_new;
   logic [etc_pkg::BYTE_W-1:0]  byte_new;
   logic                        counted;

   // Endpoint of the current side
   assign cur_addr = side_ff ? job_ff.dst_address : job_ff.src_address;
   assign cur_port = side_ff ? job_ff.dest_port : job_ff.source_port;
   assign cur_key  = {job_ff.udp, cur_addr, cur_port};

   // Saturating counter update of the current side
   always_comb begin
      base     = (status_ff == etc_pkg::ST_INSERTED) ? '0 : stats_rd_ff;
      pkt_cur  = side_ff ? base.rx_p : base.tx_p;
      byte_cur = side_ff ? base.rx_b : base.tx_b;
      pkt_sum  = {1'b0, pkt_cur} + {{etc_pkg::PKT_W{1'b0}}, 1'b1};
      byte_sum = {1'b0, byte_cur} +
                 (etc_pkg::BYTE_W + 1)'(job_ff.frame_length);
      pkt_new  = pkt_sum[etc_pkg::PKT_W] ? '1 : pkt_sum[etc_pkg::PKT_W-1:0];
      byte_new = byte_sum[etc_pkg::BYTE_W] ? '1 : byte_sum[etc_pkg::BYTE_W-1:0];
      upd      = base;
      if (side_ff) begin
         upd.rx_p = pkt_new;
         upd.rx_b = byte_new;
      end else begin
         upd.tx_p = pkt_new;
         upd.tx_b = byte_new;
      end
      counted  = (status_ff == etc_pkg::ST_UPDATED) ||
                 (status_ff == etc_pkg::ST_INSERTED);
   end

   // Sequencer: scan keys, read counters, write back and emit
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      side_in    = side_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = idx_ff[etc_pkg::IDX_W-1:0];
      slot_in    = slot_ff;
      status_in  = status_ff;
      fill_in    = fill_ff;
      pop        = 1'b0;
      key_we     = 1'b0;
      stats_we   = 1'b0;
      out_load   = 1'b0;
      out_in     = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               job_in  = head.job;
               side_in = 1'b0;
               idx_in  = '0;
               slot_in = '0;
               if (head.job.other) begin
                  status_in = etc_pkg::ST_NOTCNT;
                  state_in  = S_WRITE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < fill_ff) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
            if (rd_vld_ff && (key_rd_ff == cur_key)) begin
               rd_vld_in = 1'b0;
               slot_in   = rd_idx_ff;
               status_in = etc_pkg::ST_UPDATED;
               state_in  = S_READ;
            end else if (!rd_vld_ff && (idx_ff == fill_ff)) begin
               if (fill_ff < etc_pkg::CNT_W'(etc_pkg::TABLE_ENTRIES)) begin
                  slot_in   = fill_ff[etc_pkg::IDX_W-1:0];
                  status_in = etc_pkg::ST_INSERTED;
                  key_we    = 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  state_in  = S_READ;
               end else begin
                  slot_in   = '0;
                  status_in = etc_pkg::ST_FULL;
                  state_in  = S_WRITE;
               end
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!out_vld_ff || rsp_ch.ready) begin
               out_load              = 1'b1;
               stats_we              = counted;
               out_in.proto_kind     = job_ff.other ? etc_pkg::KIND_OTHER :
                                       (job_ff.udp ? etc_pkg::KIND_UDP : etc_pkg::KIND_TCP);
               out_in.entry_address  = job_ff.other ? '0 : cur_addr;
               out_in.entry_port     = job_ff.other ? '0 : cur_port;
               out_in.direction      = side_ff;
               out_in.slot           = slot_ff;
               out_in.status         = status_ff;
               out_in.stats          = counted ? upd : '0;
               out_in.last_of_packet = job_ff.other || side_ff;
               if (job_ff.other || side_ff) begin
                  state_in = S_IDLE;
               end else begin
                  side_in  = 1'b1;
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_vld_in = out_load || (out_vld_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      side_ff   <= side_in;
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // Key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[fill_ff[etc_pkg::IDX_W-1:0]] <= cur_key;
      end
      key_rd_ff <= key_mem[idx_ff[etc_pkg::IDX_W-1:0]];
   end

   // Counter memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (stats_we) begin
         stats_mem[slot_ff] <= upd;
      end
      stats_rd_ff <= stats_mem[slot_ff];
   end

   // Result channel
   assign rsp_ch.valid           = out_vld_ff;
   assign rsp_ch.proto_kind      = out_ff.proto_kind;
   assign rsp_ch.entry_address   = out_ff.entry_address;
   assign rsp_ch.entry_port      = out_ff.entry_port;
   assign rsp_ch.direction       = out_ff.direction;
   assign rsp_ch.slot            = etc_pkg::SLOT_OUT_W'(out_ff.slot);
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.tx_packet_count = etc_pkg::PKT_OUT_W'(out_ff.stats.tx_p);
   assign rsp_ch.tx_byte_count   = etc_pkg::BYTE_OUT_W'(out_ff.stats.tx_b);
   assign rsp_ch.rx_packet_count = etc_pkg::PKT_OUT_W'(out_ff.stats.rx_p);
   assign rsp_ch.rx_byte_count   = etc_pkg::BYTE_OUT_W'(out_ff.stats.rx_b);
   assign rsp_ch.last_of_packet  = out_ff.last_of_packet;

endmodule

// ===== src/endpoint_traffic_counter_table.sv =====
// Per-endpoint TX/RX packet and byte statistics for parsed IPv4 packets. TCP and UDP
// endpoints share one table keyed by {udp, address, port}; each counted packet gives two
// response transactions (source side TX, then destination side RX), other protocols give
// one transaction with status "not counted". A two-entry queue decouples the request side
// from the table engine, so requests are taken while the engine works. Each endpoint
// lookup scans the key memory one entry per cycle, through at most the F table entries in
// use when it starts (at most 256), and the engine waits while the response side stalls.
// No clearing pass is needed after reset.
module endpoint_traffic_counter_table (
   input  logic      clock,
   input  logic      reset,
   etc_req_if.sink   req_ch,
   etc_rsp_if.source rsp_ch
);

   etc_pkg::queue_head_type head;
   logic                    pop;

   etc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   etc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== src/etc_checker.sv =====
module etc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_proto_kind,
   input logic        rsp_direction,
   input logic [7:0]  rsp_slot,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_tx_packet_count,
   input logic [31:0] rsp_rx_packet_count,
   input logic        rsp_last_of_packet
);

   // A pending response transaction stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Uncounted packets close themselves and are marked as other protocol
   a_notcnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == etc_pkg::ST_NOTCNT) |->
      rsp_last_of_packet && (rsp_proto_kind == etc_pkg::KIND_OTHER))
      else $error("bad not-counted response");

   // Counted packets end on the destination side
   a_last_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != etc_pkg::ST_NOTCNT) |->
      (rsp_direction == rsp_last_of_packet))
      else $error("last flag does not match direction");

   // Dropped updates carry no slot and no packet counts
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == etc_pkg::ST_FULL) |->
      (rsp_slot == 8'd0) && (rsp_tx_packet_count == 32'd0) &&
      (rsp_rx_packet_count == 32'd0))
      else $error("table-full response carries data");

   // A stored update has counted at least one packet on its side
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == etc_pkg::ST_UPDATED) ||
      (rsp_status == etc_pkg::ST_INSERTED)) |->
      (rsp_direction ? (rsp_rx_packet_count != 32'd0) : (rsp_tx_packet_count != 32'd0)))
      else $error("updated entry has zero packet count");

endmodule

bind endpoint_traffic_counter_table etc_checker u_etc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_proto_kind      (rsp_ch.proto_kind),
   .rsp_direction       (rsp_ch.direction),
   .rsp_slot            (rsp_ch.slot),
   .rsp_status          (rsp_ch.status),
   .rsp_tx_packet_count (rsp_ch.tx_packet_count),
   .rsp_rx_packet_count (rsp_ch.rx_packet_count),
   .rsp_last_of_packet  (rsp_ch.last_of_packet)
);

// ===== verif/etc_stats_checker.sv =====
// Watches both channels, predicts the statistics table and compares every response
module etc_stats_checker (
   input  logic clock,
   input  logic reset,
   etc_req_if   req_mon,
   etc_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct {
      logic [1:0]  proto_kind;
      logic [31:0] entry_address;
      logic [15:0] entry_port;
      logic        direction;
      logic [7:0]  slot;
      logic [1:0]  status;
      logic [31:0] tx_packet_count;
      logic [47:0] tx_byte_count;
      logic [31:0] rx_packet_count;
      logic [47:0] rx_byte_count;
      logic        last_of_packet;
   } stats_rsp_type;

   // Shadow of the endpoint table
   logic                          shadow_valid [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::KEY_W-1:0]     shadow_key   [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::PKT_W-1:0]     shadow_tx_p  [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::BYTE_W-1:0]    shadow_tx_b  [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::PKT_W-1:0]     shadow_rx_p  [etc_pkg::TABLE_ENTRIES];
   logic [etc_pkg::BYTE_W-1:0]    shadow_rx_b  [etc_pkg::TABLE_ENTRIES];
   int                            shadow_fill;

   stats_rsp_type expected_rsps [$];

   function automatic logic [etc_pkg::PKT_W-1:0] pkt_inc(logic [etc_pkg::PKT_W-1:0] cur);
      return (&cur) ? cur : cur + 1'b1;
   endfunction

   function automatic logic [etc_pkg::BYTE_W-1:0] bytes_add(
      logic [etc_pkg::BYTE_W-1:0] cur, logic [15:0] len);
      logic [etc_pkg::BYTE_W:0] sum;
      sum = {1'b0, cur} + (etc_pkg::BYTE_W + 1)'(len);
      return sum[etc_pkg::BYTE_W] ? {etc_pkg::BYTE_W{1'b1}} : sum[etc_pkg::BYTE_W-1:0];
   endfunction

   // One endpoint update: lookup, insert on miss or drop when full, count
   function automatic stats_rsp_type update_endpoint(logic [1:0] kind, logic [31:0] addr,
                                                     logic [15:0] port, logic dir,
                                                     logic [15:0] len, logic last);
      stats_rsp_type r;
      logic [etc_pkg::KEY_W-1:0] k;
      int idx;
      k = {kind[0], addr, port};
      idx = -1;
      for (int i = 0; i < etc_pkg::TABLE_ENTRIES; i++) begin
         if (idx < 0 && shadow_valid[i] && shadow_key[i] == k) idx = i;
      end
      r = '{kind, addr, port, dir, 8'd0, etc_pkg::ST_UPDATED, '0, '0, '0, '0, last};
      if (idx < 0) begin
         if (shadow_fill >= etc_pkg::TABLE_ENTRIES) begin
            r.status = etc_pkg::ST_FULL;
            return r;
         end
         idx = shadow_fill;
         shadow_fill++;
         shadow_valid[idx] = 1'b1;
         shadow_key[idx]   = k;
         shadow_tx_p[idx]  = '0;
         shadow_tx_b[idx]  = '0;
         shadow_rx_p[idx]  = '0;
         shadow_rx_b[idx]  = '0;
         r.status = etc_pkg::ST_INSERTED;
      end
      if (!dir) begin
         shadow_tx_p[idx] = pkt_inc(shadow_tx_p[idx]);
         shadow_tx_b[idx] = bytes_add(shadow_tx_b[idx], len);
      end else begin
         shadow_rx_p[idx] = pkt_inc(shadow_rx_p[idx]);
         shadow_rx_b[idx] = bytes_add(shadow_rx_b[idx], len);
      end
      r.slot            = idx[7:0];
      r.tx_packet_count = shadow_tx_p[idx];
      r.tx_byte_count   = shadow_tx_b[idx];
      r.rx_packet_count = shadow_rx_p[idx];
      r.rx_byte_count   = shadow_rx_b[idx];
      return r;
   endfunction

   // Compare responses first, then predict from the accepted request
   always @(posedge clock) begin
      stats_rsp_type exp_r;
      logic [1:0] kind;
      if (reset) begin
         for (int i = 0; i < etc_pkg::TABLE_ENTRIES; i++) shadow_valid[i] = 1'b0;
         shadow_fill = 0;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_mon.proto_kind !== exp_r.proto_kind) begin
                  $error("proto_kind exp %0d got %0d", exp_r.proto_kind, rsp_mon.proto_kind);
                  fail_count++;
               end
               if (rsp_mon.entry_address !== exp_r.entry_address) begin
                  $error("entry_address exp %h got %h", exp_r.entry_address,
                         rsp_mon.entry_address);
                  fail_count++;
               end
               if (rsp_mon.entry_port !== exp_r.entry_port) begin
                  $error("entry_port exp %0d got %0d", exp_r.entry_port, rsp_mon.entry_port);
                  fail_count++;
               end
               if (rsp_mon.direction !== exp_r.direction) begin
                  $error("direction exp %0d got %0d", exp_r.direction, rsp_mon.direction);
                  fail_count++;
               end
               if (rsp_mon.slot !== exp_r.slot) begin
                  $error("slot exp %0d got %0d", exp_r.slot, rsp_mon.slot);
                  fail_count++;
               end
               if (rsp_mon.status !== exp_r.status) begin
                  $error("status exp %0d got %0d", exp_r.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.tx_packet_count !== exp_r.tx_packet_count) begin
                  $error("tx_packet_count exp %0d got %0d", exp_r.tx_packet_count,
                         rsp_mon.tx_packet_count);
                  fail_count++;
               end
               if (rsp_mon.tx_byte_count !== exp_r.tx_byte_count) begin
                  $error("tx_byte_count exp %0d got %0d", exp_r.tx_byte_count,
                         rsp_mon.tx_byte_count);
                  fail_count++;
               end
               if (rsp_mon.rx_packet_count !== exp_r.rx_packet_count) begin
                  $error("rx_packet_count exp %0d got %0d", exp_r.rx_packet_count,
                         rsp_mon.rx_packet_count);
                  fail_count++;
               end
               if (rsp_mon.rx_byte_count !== exp_r.rx_byte_count) begin
                  $error("rx_byte_count exp %0d got %0d", exp_r.rx_byte_count,
                         rsp_mon.rx_byte_count);
                  fail_count++;
               end
               if (rsp_mon.last_of_packet !== exp_r.last_of_packet) begin
                  $error("last_of_packet exp %0d got %0d", exp_r.last_of_packet,
                         rsp_mon.last_of_packet);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.ip_protocol == etc_pkg::PROTO_TCP ||
                req_mon.ip_protocol == etc_pkg::PROTO_UDP) begin
               kind = (req_mon.ip_protocol == etc_pkg::PROTO_UDP) ? etc_pkg::KIND_UDP :
                                                                    etc_pkg::KIND_TCP;
               expected_rsps.push_back(update_endpoint(kind, req_mon.src_address,
                  req_mon.source_port, 1'b0, req_mon.frame_length, 1'b0));
               expected_rsps.push_back(update_endpoint(kind, req_mon.dst_address,
                  req_mon.dest_port, 1'b1, req_mon.frame_length, 1'b1));
            end else begin
               expected_rsps.push_back(stats_rsp_type'{etc_pkg::KIND_OTHER, 32'd0, 16'd0,
                                        1'b0, 8'd0, etc_pkg::ST_NOTCNT,
                                        '0, '0, '0, '0, 1'b1});
            end
         end
      end
      pending_count = expected_rsps.size();
   end

endmodule

// ===== verif/tb_endpoint_traffic_counter_table.sv =====
module tb_endpoint_traffic_counter_table;

   localparam int NUM_RANDOM  = 1400;
   localparam int IDLE_LIMIT  = 20000;
   localparam int POOL_SIZE   = 48;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   logic no_gaps;
   int   rsp_stall;

   etc_req_if req_ch ();
   etc_rsp_if rsp_ch ();

   endpoint_traffic_counter_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   etc_stats_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Endpoints seen so far, reused so that lookups hit
   logic [31:0] pool_addr [POOL_SIZE];
   logic [15:0] pool_port [POOL_SIZE];
   int          pool_used;

   // Response side: random stall per transaction, none while no_gaps is set
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         draw = no_gaps ? 0 : $urandom_range(19);
         rsp_stall    <= draw;
         rsp_ch.ready <= (draw == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("endpoint_traffic_counter_table: mismatch");
            $finish;
         end
      end
   end

   // Drive one packet and hold it until accepted; keep valid up if no gap follows
   task automatic send_packet(logic [7:0] proto, logic [31:0] sa, logic [15:0] sp,
                              logic [31:0] da, logic [15:0] dp, logic [15:0] len);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.ip_protocol  <= proto;
      req_ch.src_address  <= sa;
      req_ch.source_port  <= sp;
      req_ch.dst_address  <= da;
      req_ch.dest_port    <= dp;
      req_ch.frame_length <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = no_gaps ? 0 : $urandom_range(19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pick_endpoint(output logic [31:0] addr, output logic [15:0] port);
      int k;
      if (pool_used > 0 && $urandom_range(99) < 75) begin
         k    = $urandom_range(pool_used - 1);
         addr = pool_addr[k];
         port = pool_port[k];
      end else begin
         addr = $urandom();
         port = 16'($urandom());
         if (pool_used < POOL_SIZE) begin
            k = pool_used;
            pool_used++;
         end else begin
            k = $urandom_range(POOL_SIZE - 1);
         end
         pool_addr[k] = addr;
         pool_port[k] = port;
      end
   endtask

   initial begin
      logic [31:0] sa, da;
      logic [15:0] sp, dp, len;
      logic [7:0]  proto;
      req_ch.valid        = 1'b0;
      req_ch.ip_protocol  = '0;
      req_ch.src_address  = '0;
      req_ch.source_port  = '0;
      req_ch.dst_address  = '0;
      req_ch.dest_port    = '0;
      req_ch.frame_length = '0;
      no_gaps             = 1'b0;
      pool_used           = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: other protocols, field extremes, repeats, same endpoint both sides
      send_packet(8'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_packet(8'd255, '0, '0, '0, '0, '0);
      send_packet(8'd7, 32'h1234_5678, 16'd80, 32'h8765_4321, 16'd443, 16'd60);
      send_packet(etc_pkg::PROTO_TCP, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
      send_packet(etc_pkg::PROTO_TCP, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_packet(etc_pkg::PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, 16'd1500);
      send_packet(etc_pkg::PROTO_UDP, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 16'd64);
      send_packet(etc_pkg::PROTO_UDP, 32'h0A00_0001, 16'd53, 32'h0A00_0001, 16'd53,
                  16'd100);
      send_packet(etc_pkg::PROTO_UDP, 32'h0A00_0001, 16'd53, 32'h0A00_0001, 16'd53,
                  16'hFFFF);
      send_packet(etc_pkg::PROTO_TCP, 32'h0A00_0001, 16'd53, 32'h0A00_0002, 16'd53,
                  16'd40);
      send_packet(8'd16, '0, '0, '0, '0, 16'd1);
      send_packet(8'd18, '0, '0, '0, '0, 16'd1);
      send_packet(etc_pkg::PROTO_TCP, 32'hC0A8_0101, 16'd1, 32'hC0A8_0101, 16'd1, 16'd1);

      // Random traffic; table fills and then drops new endpoints
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 150 == 0) no_gaps = ($urandom_range(3) == 0);
         if (n == NUM_RANDOM / 2) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         case ($urandom_range(9))
            0:       proto = 8'($urandom());
            1, 2, 3: proto = etc_pkg::PROTO_UDP;
            default: proto = etc_pkg::PROTO_TCP;
         endcase
         pick_endpoint(sa, sp);
         if ($urandom_range(19) == 0) begin
            da = sa;
            dp = sp;
         end else begin
            pick_endpoint(da, dp);
         end
         len = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom());
         send_packet(proto, sa, sp, da, dp, len);
      end
      req_ch.valid <= 1'b0;
      no_gaps = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0)
         $display("endpoint_traffic_counter_table: match");
      else
         $display("endpoint_traffic_counter_table: mismatch");
      $finish;
   end

endmodule

// ===== endpoint_traffic_counter_table.f =====
src/etc_pkg.sv
src/etc_if.sv
src/etc_front.sv
src/etc_back.sv
src/endpoint_traffic_counter_table.sv
src/etc_checker.sv
verif/etc_stats_checker.sv
verif/tb_endpoint_traffic_counter_table.sv
